FILE: src/xss_pkg.sv
// Shared types, constants and character helpers of the XML structure sniffer.
// Used by every design module but the checker; depends on nothing.
package xss_pkg;

  localparam int STACK_DEPTH_DEF = 64;
  localparam int NAME_MAX_DEF    = 32;
  localparam int COUNT_WIDTH_DEF = 16;

  localparam int          LIMIT_W     = 17;
  localparam logic [16:0] LIMIT_RESET = 17'h10000;
  localparam int          CUR_W       = 7;
  localparam int          NUM_CNT     = 10;
  localparam int          TDATA_OUT_W = 48;

  // tag counter slots
  localparam int C_START   = 0;
  localparam int C_END     = 1;
  localparam int C_MATCHED = 2;
  localparam int C_SELF    = 3;
  localparam int C_ATTR    = 4;
  localparam int C_XMLNS   = 5;
  localparam int C_XMLDECL = 6;
  localparam int C_DOCTYPE = 7;
  localparam int C_COMMENT = 8;
  localparam int C_CDATA   = 9;

  // configuration register index
  localparam logic REG_SAMPLE_LIMIT = 1'b0;

  typedef enum logic [4:0] {
    M_BOM0, M_BOM1, M_BOM2, M_TEXT, M_LT, M_BANG, M_KW_COMMENT, M_KW_CDATA,
    M_KW_DOCTYPE, M_COMMENT, M_CDATA, M_PI_START, M_PI_TARGET, M_PI_BODY,
    M_DOCTYPE, M_ETAG_START, M_ETAG_NAME, M_ETAG_WS, M_TAG_NAME, M_TAG_LOOP,
    M_TAG_SLASH, M_ATTR_NAME, M_ATTR_EQ, M_ATTR_VALWS, M_ATTR_VALUE, M_VALUE_LT
  } scan_mode_e;

  typedef struct packed {
    logic invalid;
    logic stop;
    logic root_seen;
    logic root_closed;
    logic separated;
    logic qmark;
    logic mismatch;
  } flags_t;

  typedef struct packed {
    logic zero;
    logic root_closed;
  } snap_stat_t;

  function automatic logic is_ws(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0A;
  endfunction

  function automatic logic is_name_start(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_" || c == ":";
  endfunction

  function automatic logic is_name_char(input logic [7:0] c);
    return is_name_start(c) || (c >= "0" && c <= "9") || c == "-" || c == ".";
  endfunction

  function automatic logic [7:0] kw_char(input scan_mode_e m, input logic [2:0] idx);
    logic [7:0] r;
    r = 8'h00;
    case (m)
      M_KW_COMMENT: r = "-";
      M_KW_CDATA: begin
        case (idx)
          3'd1: r = "C";
          3'd2: r = "D";
          3'd3: r = "A";
          3'd4: r = "T";
          3'd5: r = "A";
          3'd6: r = "[";
          default: r = 8'h00;
        endcase
      end
      default: begin
        case (idx)
          3'd1: r = "O";
          3'd2: r = "C";
          3'd3: r = "T";
          3'd4: r = "Y";
          3'd5: r = "P";
          3'd6: r = "E";
          default: r = 8'h00;
        endcase
      end
    endcase
    return r;
  endfunction

  function automatic logic [7:0] xml_char(input logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0: r = "x";
      2'd1: r = "m";
      2'd2: r = "l";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] ns_char(input logic [2:0] idx);
    logic [7:0] r;
    case (idx)
      3'd0: r = "x";
      3'd1: r = "m";
      3'd2: r = "l";
      3'd3: r = "n";
      3'd4: r = "s";
      3'd5: r = ":";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

FILE: src/xss_scan.sv
// Byte scanner of the XML structure sniffer: mode register, name stack memories,
// tag counters and the end-of-text snapshot register. Depends on xss_pkg.
module xss_scan #(
  parameter int STACK_DEPTH = xss_pkg::STACK_DEPTH_DEF,
  parameter int NAME_MAX    = xss_pkg::NAME_MAX_DEF,
  parameter int COUNT_WIDTH = xss_pkg::COUNT_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_i,
  input  logic [7:0]                   byte_i,
  input  logic                         last_i,
  input  logic [xss_pkg::LIMIT_W-1:0]  limit_i,
  input  logic                         snap_pop_i,
  output logic                         snap_room_o,
  output logic                         snap_valid_o,
  output logic [COUNT_WIDTH-1:0]       snap_cnt_o [xss_pkg::NUM_CNT],
  output xss_pkg::snap_stat_t          snap_stat_o
);

  localparam int DW  = $clog2(STACK_DEPTH + 1);
  localparam int RW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CLW = $clog2(NAME_MAX);
  localparam int LW  = $clog2(NAME_MAX + 1);
  localparam int CW  = COUNT_WIDTH;
  localparam int UW  = xss_pkg::CUR_W;

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] a);
    return (&a) ? a : a + 1'b1;
  endfunction

  function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a, input logic [CW-1:0] b);
    logic [CW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CW] ? {CW{1'b1}} : s[CW-1:0];
  endfunction

  xss_pkg::scan_mode_e mode_q, mode_d;
  logic [DW-1:0]  depth_q, depth_d;
  logic [UW-1:0]  cursor_q, cursor_d;
  logic [7:0]     quote_q, quote_d;
  logic [15:0]    nest_q, nest_d;
  logic [CW-1:0]  cnt_q [xss_pkg::NUM_CNT];
  logic [CW-1:0]  cnt_d [xss_pkg::NUM_CNT];
  logic [CW-1:0]  pend_q [2];
  logic [CW-1:0]  pend_d [2];
  xss_pkg::flags_t flags_q, flags_d;
  logic [xss_pkg::LIMIT_W-1:0] bytes_q, bytes_d;

  logic [7:0]     name_mem_q [STACK_DEPTH][NAME_MAX];
  logic [LW-1:0]  len_mem_q [STACK_DEPTH];
  logic [7:0]     rd_byte_q;
  logic [LW-1:0]  rd_len_q;

  logic           name_we, len_we;
  logic [RW-1:0]  wr_row;
  logic [CLW-1:0] name_col;
  logic [LW-1:0]  len_wdata;
  logic [RW-1:0]  rd_row;
  logic [CLW-1:0] rd_col;
  logic [DW-1:0]  depth_m1;

  logic           redo, close_req, close_self;
  logic           snap_load;
  logic [CW-1:0]  snap_cnt_d [xss_pkg::NUM_CNT];
  xss_pkg::snap_stat_t snap_stat_d;
  logic           snap_v_q;

  logic [7:0]     c;
  logic [UW-1:0]  kw_len;

  assign c = byte_i;

  always_comb begin
    mode_d    = mode_q;
    depth_d   = depth_q;
    cursor_d  = cursor_q;
    quote_d   = quote_q;
    nest_d    = nest_q;
    cnt_d     = cnt_q;
    pend_d    = pend_q;
    flags_d   = flags_q;
    bytes_d   = bytes_q;
    name_we   = 1'b0;
    len_we    = 1'b0;
    wr_row    = depth_q[RW-1:0];
    name_col  = cursor_q[CLW-1:0];
    len_wdata = cursor_q[LW-1:0];
    redo      = 1'b0;
    close_req = 1'b0;
    close_self = 1'b0;
    kw_len    = UW'(7);
    snap_load = 1'b0;
    snap_cnt_d = cnt_q;
    snap_stat_d = '0;

    if (step_i && (bytes_q < limit_i)) begin
      bytes_d = bytes_q + 1'b1;
      if (!flags_q.invalid && !flags_q.stop) begin
        // a byte other than the first BOM byte falls straight into text
        if (mode_q == xss_pkg::M_BOM0 && c != 8'hEF) mode_d = xss_pkg::M_TEXT;
        redo = 1'b1;
        for (int p = 0; p < 2; p++) begin
          if (redo) begin
            redo = 1'b0;
            case (mode_d)
              xss_pkg::M_BOM0: mode_d = xss_pkg::M_BOM1;
              xss_pkg::M_BOM1: begin
                if (c == 8'hBB) mode_d = xss_pkg::M_BOM2; else flags_d.invalid = 1'b1;
              end
              xss_pkg::M_BOM2: begin
                if (c == 8'hBF) mode_d = xss_pkg::M_TEXT; else flags_d.invalid = 1'b1;
              end
              xss_pkg::M_TEXT: begin
                if (c == "<") mode_d = xss_pkg::M_LT;
                else if (depth_d == '0 && !xss_pkg::is_ws(c)) flags_d.invalid = 1'b1;
              end
              xss_pkg::M_LT: begin
                if (c == "!") mode_d = xss_pkg::M_BANG;
                else if (c == "?") mode_d = xss_pkg::M_PI_START;
                else if (c == "/") mode_d = xss_pkg::M_ETAG_START;
                else if (xss_pkg::is_name_start(c)) begin
                  mode_d = xss_pkg::M_TAG_NAME;
                  cursor_d = '0;
                  pend_d[0] = '0;
                  pend_d[1] = '0;
                  redo = 1'b1;
                end else flags_d.invalid = 1'b1;
              end
              xss_pkg::M_BANG: begin
                cursor_d = UW'(1);
                if (c == "-") mode_d = xss_pkg::M_KW_COMMENT;
                else if (c == "[") mode_d = xss_pkg::M_KW_CDATA;
                else if (c == "D") mode_d = xss_pkg::M_KW_DOCTYPE;
                else flags_d.invalid = 1'b1;
              end
              xss_pkg::M_KW_COMMENT, xss_pkg::M_KW_CDATA, xss_pkg::M_KW_DOCTYPE: begin
                kw_len = (mode_d == xss_pkg::M_KW_COMMENT) ? UW'(2) : UW'(7);
                if (cursor_d >= kw_len || c != xss_pkg::kw_char(mode_d, cursor_d[2:0])) begin
                  flags_d.invalid = 1'b1;
                end else if (cursor_d + 1'b1 < kw_len) begin
                  cursor_d = cursor_d + 1'b1;
                end else begin
                  cursor_d = '0;
                  quote_d  = '0;
                  nest_d   = '0;
                  if (mode_d == xss_pkg::M_KW_COMMENT) mode_d = xss_pkg::M_COMMENT;
                  else if (mode_d == xss_pkg::M_KW_CDATA) begin
                    if (depth_d == '0) flags_d.invalid = 1'b1; else mode_d = xss_pkg::M_CDATA;
                  end else begin
                    if (flags_d.root_seen) flags_d.invalid = 1'b1;
                    else mode_d = xss_pkg::M_DOCTYPE;
                  end
                end
              end
              xss_pkg::M_COMMENT, xss_pkg::M_CDATA: begin
                if (c == ((mode_d == xss_pkg::M_COMMENT) ? 8'h2D : 8'h5D)) begin
                  if (cursor_d < UW'(2)) cursor_d = cursor_d + 1'b1;
                end else if (c == ">" && cursor_d == UW'(2)) begin
                  if (mode_d == xss_pkg::M_COMMENT) begin
                    cnt_d[xss_pkg::C_COMMENT] = sat_inc(cnt_d[xss_pkg::C_COMMENT]);
                  end else begin
                    cnt_d[xss_pkg::C_CDATA] = sat_inc(cnt_d[xss_pkg::C_CDATA]);
                  end
                  cursor_d = '0;
                  mode_d = xss_pkg::M_TEXT;
                end else cursor_d = '0;
              end
              xss_pkg::M_PI_START: begin
                if (xss_pkg::is_name_start(c)) begin
                  mode_d = xss_pkg::M_PI_TARGET;
                  cursor_d = '0;
                  flags_d.mismatch = 1'b0;
                  redo = 1'b1;
                end else flags_d.invalid = 1'b1;
              end
              xss_pkg::M_PI_TARGET: begin
                if (xss_pkg::is_name_char(c)) begin
                  if (cursor_d >= UW'(3) || c != xss_pkg::xml_char(cursor_d[1:0])) begin
                    flags_d.mismatch = 1'b1;
                  end
                  if (cursor_d < UW'(63)) cursor_d = cursor_d + 1'b1;
                end else begin
                  mode_d = xss_pkg::M_PI_BODY;
                  quote_d = '0;
                  flags_d.qmark = 1'b0;
                  redo = 1'b1;
                end
              end
              xss_pkg::M_PI_BODY: begin
                if (quote_d != '0) begin
                  if (c == quote_d) quote_d = '0;
                end else if (flags_d.qmark && c == ">") begin
                  if (!flags_d.root_seen && !flags_d.mismatch && cursor_d == UW'(3)) begin
                    cnt_d[xss_pkg::C_XMLDECL] = sat_inc(cnt_d[xss_pkg::C_XMLDECL]);
                  end
                  flags_d.qmark = 1'b0;
                  mode_d = xss_pkg::M_TEXT;
                end else begin
                  flags_d.qmark = 1'b0;
                  if (c == 8'h27 || c == 8'h22) quote_d = c;
                  else if (c == "?") flags_d.qmark = 1'b1;
                  else if (c == "<") flags_d.invalid = 1'b1;
                end
              end
              xss_pkg::M_DOCTYPE: begin
                if (quote_d != '0) begin
                  if (c == quote_d) quote_d = '0;
                end else if (c == 8'h27 || c == 8'h22) quote_d = c;
                else if (c == "[") begin
                  if (nest_d != 16'hFFFF) nest_d = nest_d + 1'b1;
                end else if (c == "]" && nest_d != '0) nest_d = nest_d - 1'b1;
                else if (c == ">" && nest_d == '0) begin
                  cnt_d[xss_pkg::C_DOCTYPE] = sat_inc(cnt_d[xss_pkg::C_DOCTYPE]);
                  mode_d = xss_pkg::M_TEXT;
                end
              end
              xss_pkg::M_ETAG_START: begin
                if (xss_pkg::is_name_start(c)) begin
                  mode_d = xss_pkg::M_ETAG_NAME;
                  cursor_d = '0;
                  flags_d.mismatch = 1'b0;
                  redo = 1'b1;
                end else flags_d.invalid = 1'b1;
              end
              xss_pkg::M_ETAG_NAME: begin
                // compare against the prefetched byte of the top stack entry
                if (xss_pkg::is_name_char(c)) begin
                  if (cursor_d >= UW'(NAME_MAX)) flags_d.stop = 1'b1;
                  else begin
                    if (depth_d == '0 || cursor_d >= UW'(rd_len_q) || rd_byte_q != c) begin
                      flags_d.mismatch = 1'b1;
                    end
                    cursor_d = cursor_d + 1'b1;
                  end
                end else begin
                  if (depth_d == '0 || cursor_d != UW'(rd_len_q)) flags_d.mismatch = 1'b1;
                  mode_d = xss_pkg::M_ETAG_WS;
                  redo = 1'b1;
                end
              end
              xss_pkg::M_ETAG_WS: begin
                if (!xss_pkg::is_ws(c)) begin
                  if (c == ">" && !flags_d.mismatch && depth_d != '0) begin
                    cnt_d[xss_pkg::C_END] = sat_inc(cnt_d[xss_pkg::C_END]);
                    cnt_d[xss_pkg::C_MATCHED] = sat_inc(cnt_d[xss_pkg::C_MATCHED]);
                    depth_d = depth_d - 1'b1;
                    if (depth_d == '0) flags_d.root_closed = 1'b1;
                    mode_d = xss_pkg::M_TEXT;
                  end else flags_d.invalid = 1'b1;
                end
              end
              xss_pkg::M_TAG_NAME: begin
                if (xss_pkg::is_name_char(c)) begin
                  if (cursor_d >= UW'(NAME_MAX)) flags_d.stop = 1'b1;
                  else begin
                    if (depth_d < DW'(STACK_DEPTH)) begin
                      name_we = 1'b1;
                      name_col = cursor_d[CLW-1:0];
                    end
                    cursor_d = cursor_d + 1'b1;
                  end
                end else begin
                  if (depth_d < DW'(STACK_DEPTH)) begin
                    len_we = 1'b1;
                    len_wdata = cursor_d[LW-1:0];
                  end
                  mode_d = xss_pkg::M_TAG_LOOP;
                  flags_d.separated = 1'b0;
                  redo = 1'b1;
                end
              end
              xss_pkg::M_TAG_LOOP: begin
                if (xss_pkg::is_ws(c)) flags_d.separated = 1'b1;
                else if (c == ">") close_req = 1'b1;
                else if (c == "/") mode_d = xss_pkg::M_TAG_SLASH;
                else if (!flags_d.separated || !xss_pkg::is_name_start(c)) begin
                  flags_d.invalid = 1'b1;
                end else begin
                  mode_d = xss_pkg::M_ATTR_NAME;
                  cursor_d = '0;
                  flags_d.mismatch = 1'b0;
                  redo = 1'b1;
                end
              end
              xss_pkg::M_TAG_SLASH: begin
                if (c == ">") begin
                  close_req = 1'b1;
                  close_self = 1'b1;
                end else flags_d.invalid = 1'b1;
              end
              xss_pkg::M_ATTR_NAME: begin
                if (xss_pkg::is_name_char(c)) begin
                  if (cursor_d < UW'(6) && c != xss_pkg::ns_char(cursor_d[2:0])) begin
                    flags_d.mismatch = 1'b1;
                  end
                  if (cursor_d < UW'(63)) cursor_d = cursor_d + 1'b1;
                end else begin
                  mode_d = xss_pkg::M_ATTR_EQ;
                  redo = 1'b1;
                end
              end
              xss_pkg::M_ATTR_EQ: begin
                if (!xss_pkg::is_ws(c)) begin
                  if (c == "=") mode_d = xss_pkg::M_ATTR_VALWS; else flags_d.invalid = 1'b1;
                end
              end
              xss_pkg::M_ATTR_VALWS: begin
                if (!xss_pkg::is_ws(c)) begin
                  if (c == 8'h27 || c == 8'h22) begin
                    quote_d = c;
                    mode_d = xss_pkg::M_ATTR_VALUE;
                  end else flags_d.invalid = 1'b1;
                end
              end
              xss_pkg::M_ATTR_VALUE: begin
                if (c == quote_d) begin
                  pend_d[0] = sat_inc(pend_d[0]);
                  if (!flags_d.mismatch && (cursor_d == UW'(5) || cursor_d > UW'(6))) begin
                    pend_d[1] = sat_inc(pend_d[1]);
                  end
                  quote_d = '0;
                  flags_d.separated = 1'b0;
                  mode_d = xss_pkg::M_TAG_LOOP;
                end else if (c == "<") mode_d = xss_pkg::M_VALUE_LT;
              end
              default: flags_d.invalid = 1'b1;
            endcase
            if (flags_d.invalid || flags_d.stop) redo = 1'b0;
          end
        end

        // start tag closes: count it, fold in its attributes, push or latch root
        if (close_req) begin
          cnt_d[xss_pkg::C_START] = sat_inc(cnt_d[xss_pkg::C_START]);
          cnt_d[xss_pkg::C_ATTR]  = sat_add(cnt_d[xss_pkg::C_ATTR], pend_d[0]);
          cnt_d[xss_pkg::C_XMLNS] = sat_add(cnt_d[xss_pkg::C_XMLNS], pend_d[1]);
          mode_d = xss_pkg::M_TEXT;
          if (depth_d == '0 && (flags_d.root_seen || flags_d.root_closed)) begin
            flags_d.invalid = 1'b1;
          end else begin
            if (depth_d == '0) flags_d.root_seen = 1'b1;
            if (close_self) begin
              cnt_d[xss_pkg::C_SELF] = sat_inc(cnt_d[xss_pkg::C_SELF]);
              cnt_d[xss_pkg::C_MATCHED] = sat_inc(cnt_d[xss_pkg::C_MATCHED]);
              if (depth_d == '0) flags_d.root_closed = 1'b1;
            end else if (depth_d >= DW'(STACK_DEPTH)) begin
              flags_d.stop = 1'b1;
            end else begin
              depth_d = depth_d + 1'b1;
            end
          end
        end
      end
    end

    if (step_i && last_i) begin
      // text ending in the middle of a keyword, BOM or markup opener is invalid
      if (!flags_d.invalid && !flags_d.stop &&
          (mode_d inside {xss_pkg::M_BOM1, xss_pkg::M_BOM2, xss_pkg::M_BANG,
                          xss_pkg::M_KW_COMMENT, xss_pkg::M_KW_CDATA, xss_pkg::M_KW_DOCTYPE,
                          xss_pkg::M_PI_START, xss_pkg::M_TAG_SLASH})) begin
        flags_d.invalid = 1'b1;
      end
      snap_load = 1'b1;
      snap_cnt_d = cnt_d;
      snap_stat_d.zero = flags_d.invalid || !flags_d.root_seen;
      snap_stat_d.root_closed = flags_d.root_closed;
      mode_d   = xss_pkg::M_BOM0;
      depth_d  = '0;
      cursor_d = '0;
      quote_d  = '0;
      nest_d   = '0;
      for (int i = 0; i < xss_pkg::NUM_CNT; i++) cnt_d[i] = '0;
      pend_d[0] = '0;
      pend_d[1] = '0;
      flags_d  = '0;
      bytes_d  = '0;
    end
  end

  // prefetch the top entry for the byte the next step compares
  assign depth_m1 = depth_d - 1'b1;
  assign rd_row   = depth_m1[RW-1:0];
  assign rd_col   = (mode_d == xss_pkg::M_ETAG_NAME) ? cursor_d[CLW-1:0] : '0;

  always_ff @(posedge clk_i) begin
    if (name_we) name_mem_q[wr_row][name_col] <= c;
    if (len_we) len_mem_q[wr_row] <= len_wdata;
    rd_byte_q <= name_mem_q[rd_row][rd_col];
    // a length written in this cycle may be the one read for the new top
    rd_len_q <= (len_we && wr_row == rd_row) ? len_wdata : len_mem_q[rd_row];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= xss_pkg::M_BOM0;
      depth_q  <= '0;
      cursor_q <= '0;
      quote_q  <= '0;
      nest_q   <= '0;
      for (int i = 0; i < xss_pkg::NUM_CNT; i++) cnt_q[i] <= '0;
      pend_q[0] <= '0;
      pend_q[1] <= '0;
      flags_q  <= '0;
      bytes_q  <= '0;
      snap_v_q <= 1'b0;
    end else begin
      mode_q   <= mode_d;
      depth_q  <= depth_d;
      cursor_q <= cursor_d;
      quote_q  <= quote_d;
      nest_q   <= nest_d;
      cnt_q    <= cnt_d;
      pend_q   <= pend_d;
      flags_q  <= flags_d;
      bytes_q  <= bytes_d;
      if (snap_load) snap_v_q <= 1'b1;
      else if (snap_pop_i) snap_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (snap_load) begin
      snap_cnt_o  <= snap_cnt_d;
      snap_stat_o <= snap_stat_d;
    end
  end

  assign snap_valid_o = snap_v_q;
  assign snap_room_o  = !snap_v_q || snap_pop_i;

endmodule

FILE: src/xss_emit.sv
// Evidence stage of the XML structure sniffer: turns a final count snapshot into
// the result word and holds it in the output register. Depends on xss_pkg.
module xss_emit #(
  parameter int COUNT_WIDTH = xss_pkg::COUNT_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             snap_valid_i,
  input  logic [COUNT_WIDTH-1:0]           snap_cnt_i [xss_pkg::NUM_CNT],
  input  xss_pkg::snap_stat_t              snap_stat_i,
  output logic                             snap_pop_o,
  output logic                             m_valid_o,
  input  logic                             m_ready_i,
  output logic [xss_pkg::TDATA_OUT_W-1:0]  m_data_o
);

  function automatic logic [39:0] cap(input logic [39:0] v, input logic [39:0] m);
    return (v < m) ? v : m;
  endfunction

  logic [39:0] st, en, mt, sf, at, xn, xd, dt, cm, cd;
  logic [39:0] tags, score, sig_sum;
  logic [15:0] tags_f;
  logic [20:0] score_f;
  logic [2:0]  strong_f;
  logic        dec_f;
  logic [xss_pkg::TDATA_OUT_W-1:0] data_d;
  logic        out_v_q;

  always_comb begin
    st = 40'(snap_cnt_i[xss_pkg::C_START]);
    en = 40'(snap_cnt_i[xss_pkg::C_END]);
    mt = 40'(snap_cnt_i[xss_pkg::C_MATCHED]);
    sf = 40'(snap_cnt_i[xss_pkg::C_SELF]);
    at = 40'(snap_cnt_i[xss_pkg::C_ATTR]);
    xn = 40'(snap_cnt_i[xss_pkg::C_XMLNS]);
    xd = 40'(snap_cnt_i[xss_pkg::C_XMLDECL]);
    dt = 40'(snap_cnt_i[xss_pkg::C_DOCTYPE]);
    cm = 40'(snap_cnt_i[xss_pkg::C_COMMENT]);
    cd = 40'(snap_cnt_i[xss_pkg::C_CDATA]);
    tags  = st + en;
    score = cap(st, 40'd12) * 40'd2 + cap(mt, 40'd8) * 40'd4 + cap(at, 40'd8)
          + xd * 40'd10 + dt * 40'd8 + cap(xn, 40'd2) * 40'd8
          + cap(cm, 40'd2) * 40'd2 + cap(cd, 40'd2) * 40'd4;
    sig_sum = mt + xd * 40'd2 + dt * 40'd2 + xn * 40'd2
            + (snap_stat_i.root_closed ? 40'd2 : 40'd0);
    tags_f   = (tags > 40'd65535) ? 16'hFFFF : tags[15:0];
    score_f  = (score > 40'd2097151) ? 21'h1FFFFF : score[20:0];
    strong_f = (sig_sum > 40'd4) ? 3'd4 : sig_sum[2:0];
    dec_f = (st != '0 && (xd != '0 || dt != '0 || xn != '0))
         || (snap_stat_i.root_closed && mt >= 40'd2)
         || (st >= 40'd3 && mt >= 40'd2)
         || (st >= 40'd4 && sf >= 40'd2);
    if (snap_stat_i.zero) begin
      tags_f = '0;
      score_f = '0;
      strong_f = '0;
      dec_f = 1'b0;
    end
    data_d = {7'd0, dec_f, strong_f, score_f, tags_f};
  end

  assign snap_pop_o = snap_valid_i && (!out_v_q || m_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (snap_pop_o) begin
      out_v_q <= 1'b1;
    end else if (m_ready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (snap_pop_o) m_data_o <= data_d;
  end

  assign m_valid_o = out_v_q;

endmodule

FILE: src/xml_structure_sniffer_unit.sv
// Top level of the XML structure sniffer: APB register, input register, scanner
// and evidence stage. Depends on xss_pkg, xss_scan and xss_emit.
//
//  channel   | direction | handshake                  | payload
//  ----------+-----------+----------------------------+------------------------------
//  s_axis    | in        | tvalid/tready              | tdata[7:0] text byte, tlast
//  m_axis    | out       | tvalid/tready              | tdata[47:0] evidence result
//  apb       | in        | psel/penable, pready = 1   | reg 0 at 0x0: sample_limit
//
// One byte per cycle sustained unless the input stalls: each word is held in the input
// register, then the scanner advances its mode, stack and counters for it.
// A result passes from its last word through the snapshot, then the output register.
// Reset clears all control state; stack memories are not cleared and need no sweep.
// The input stalls only when a last word meets a full snapshot and a full output.
module xml_structure_sniffer_unit #(
  parameter int STACK_DEPTH = xss_pkg::STACK_DEPTH_DEF,
  parameter int NAME_MAX    = xss_pkg::NAME_MAX_DEF,
  parameter int COUNT_WIDTH = xss_pkg::COUNT_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
  input  logic        s_axis_tlast,   // is_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [15:0] structural_tags, [36:16] score,
                                      // [39:37] strong_signals, [40] decisive
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [xss_pkg::LIMIT_W-1:0] limit_q;
  logic       in_v_q, in_last_q;
  logic [7:0] in_byte_q;
  logic       go;
  logic       snap_room, snap_valid, snap_pop;
  logic [COUNT_WIDTH-1:0] snap_cnt [xss_pkg::NUM_CNT];
  xss_pkg::snap_stat_t snap_stat;

  // configuration: write on the access cycle, read back the limit
  assign pready = 1'b1;
  assign prdata = (paddr[2] == xss_pkg::REG_SAMPLE_LIMIT) ? 32'(limit_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= xss_pkg::LIMIT_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == xss_pkg::REG_SAMPLE_LIMIT) begin
      limit_q <= pwdata[xss_pkg::LIMIT_W-1:0];
    end
  end

  // hold a last word until the snapshot register has room; other words advance
  assign go            = in_v_q && (!in_last_q || snap_room);
  assign s_axis_tready = !in_v_q || go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_v_q <= 1'b1;
    end else if (go) begin
      in_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  xss_scan #(
    .STACK_DEPTH(STACK_DEPTH),
    .NAME_MAX(NAME_MAX),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_scan (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .step_i(go),
    .byte_i(in_byte_q),
    .last_i(in_last_q),
    .limit_i(limit_q),
    .snap_pop_i(snap_pop),
    .snap_room_o(snap_room),
    .snap_valid_o(snap_valid),
    .snap_cnt_o(snap_cnt),
    .snap_stat_o(snap_stat)
  );

  xss_emit #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_emit (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .snap_valid_i(snap_valid),
    .snap_cnt_i(snap_cnt),
    .snap_stat_i(snap_stat),
    .snap_pop_o(snap_pop),
    .m_valid_o(m_axis_tvalid),
    .m_ready_i(m_axis_tready),
    .m_data_o(m_axis_tdata)
  );

endmodule

FILE: src/xss_checker.sv
// Port-level checks of the XML structure sniffer, bound to the top level.
// Depends on xml_structure_sniffer_unit.
module xss_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_strong_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[39:37] <= 3'd4)
    else $error("strong signal count above four");

  // a zero score only comes from a zeroed result
  a_zero_score: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[36:16] == 21'd0 |->
      m_axis_tdata[15:0] == 16'd0 && m_axis_tdata[39:37] == 3'd0 && !m_axis_tdata[40])
    else $error("nonzero fields with zero score");

  // with no result pending the input never stalls
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while output empty");

endmodule

bind xml_structure_sniffer_unit xss_checker u_xss_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata)
);

FILE: test/tb.sv
// Self-checking bench for the XML structure sniffer: byte stream in, evidence words out.
// Predicts each result with an in-bench scanner model and checks every output field.
// Depends on xss_pkg and xml_structure_sniffer_unit.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = xss_pkg::STACK_DEPTH_DEF;
  localparam int NMAX  = xss_pkg::NAME_MAX_DEF;
  localparam logic [15:0] CMAX = 16'hFFFF;
  localparam logic [2:0] ADDR_SAMPLE_LIMIT = 3'd0;

  typedef struct packed {
    logic        decisive;
    logic [2:0]  sigs;
    logic [20:0] score;
    logic [15:0] tags;
  } evidence_t;

  // Scoreboard: holds the scanner shadow state and the queue of expected words.
  class sniff_board;
    evidence_t   pending[$];
    int          errors;
    int          results;
    logic [16:0] limit;
    xss_pkg::scan_mode_e mode;
    logic [7:0]  names[DEPTH][NMAX];
    int          lens[DEPTH];
    int          depth, cur, subset;
    logic [7:0]  quote;
    int          cnt[xss_pkg::NUM_CNT];
    int          pend_attr, pend_ns;
    logic        f_inv, f_stop, f_seen, f_closed, f_sep, f_q, f_mis;
    int          seen;

    function void restart();
      mode = xss_pkg::M_BOM0; depth = 0; cur = 0; quote = 0; subset = 0;
      foreach (cnt[k]) cnt[k] = 0;
      pend_attr = 0; pend_ns = 0; seen = 0;
      {f_inv, f_stop, f_seen, f_closed, f_sep, f_q, f_mis} = '0;
    endfunction

    function void bump(int k);
      if (cnt[k] < CMAX) cnt[k]++;
    endfunction

    function void close_tag(bit self_close);
      bump(xss_pkg::C_START);
      cnt[xss_pkg::C_ATTR]  = (cnt[xss_pkg::C_ATTR] + pend_attr > CMAX)
                              ? CMAX : cnt[xss_pkg::C_ATTR] + pend_attr;
      cnt[xss_pkg::C_XMLNS] = (cnt[xss_pkg::C_XMLNS] + pend_ns > CMAX)
                              ? CMAX : cnt[xss_pkg::C_XMLNS] + pend_ns;
      mode = xss_pkg::M_TEXT;
      if (depth == 0) begin
        if (f_seen || f_closed) begin
          f_inv = 1;
          return;
        end
        f_seen = 1;
      end
      if (self_close) begin
        bump(xss_pkg::C_SELF); bump(xss_pkg::C_MATCHED);
        if (depth == 0) f_closed = 1;
      end else if (depth >= DEPTH) f_stop = 1;
      else depth++;
    endfunction

    function void keyword(logic [7:0] c, string kw);
      if (cur >= kw.len() || c != kw[cur]) begin
        f_inv = 1;
        return;
      end
      cur++;
      if (cur < kw.len()) return;
      cur = 0; quote = 0; subset = 0;
      if (mode == xss_pkg::M_KW_COMMENT) mode = xss_pkg::M_COMMENT;
      else if (mode == xss_pkg::M_KW_CDATA) begin
        if (depth == 0) f_inv = 1; else mode = xss_pkg::M_CDATA;
      end else begin
        if (f_seen) f_inv = 1; else mode = xss_pkg::M_DOCTYPE;
      end
    endfunction

    function void scan(logic [7:0] c);
      bit redo;
      logic [7:0] mark;
      string ns;
      ns = "xmlns:";
      do begin
        redo = 0;
        case (mode)
          xss_pkg::M_BOM0: begin
            if (c == 8'hEF) mode = xss_pkg::M_BOM1;
            else begin mode = xss_pkg::M_TEXT; redo = 1; end
          end
          xss_pkg::M_BOM1: if (c == 8'hBB) mode = xss_pkg::M_BOM2; else f_inv = 1;
          xss_pkg::M_BOM2: if (c == 8'hBF) mode = xss_pkg::M_TEXT; else f_inv = 1;
          xss_pkg::M_TEXT: begin
            if (c == "<") mode = xss_pkg::M_LT;
            else if (depth == 0 && !xss_pkg::is_ws(c)) f_inv = 1;
          end
          xss_pkg::M_LT: begin
            if (c == "!") mode = xss_pkg::M_BANG;
            else if (c == "?") mode = xss_pkg::M_PI_START;
            else if (c == "/") mode = xss_pkg::M_ETAG_START;
            else if (xss_pkg::is_name_start(c)) begin
              mode = xss_pkg::M_TAG_NAME; cur = 0; pend_attr = 0; pend_ns = 0; redo = 1;
            end else f_inv = 1;
          end
          xss_pkg::M_BANG: begin
            cur = 1;
            if (c == "-") mode = xss_pkg::M_KW_COMMENT;
            else if (c == "[") mode = xss_pkg::M_KW_CDATA;
            else if (c == "D") mode = xss_pkg::M_KW_DOCTYPE;
            else f_inv = 1;
          end
          xss_pkg::M_KW_COMMENT: keyword(c, "--");
          xss_pkg::M_KW_CDATA:   keyword(c, "[CDATA[");
          xss_pkg::M_KW_DOCTYPE: keyword(c, "DOCTYPE");
          xss_pkg::M_COMMENT, xss_pkg::M_CDATA: begin
            mark = (mode == xss_pkg::M_COMMENT) ? "-" : "]";
            if (c == mark) begin
              if (cur < 2) cur++;
            end else if (c == ">" && cur == 2) begin
              bump(mode == xss_pkg::M_COMMENT ? xss_pkg::C_COMMENT : xss_pkg::C_CDATA);
              cur = 0; mode = xss_pkg::M_TEXT;
            end else cur = 0;
          end
          xss_pkg::M_PI_START: begin
            if (xss_pkg::is_name_start(c)) begin
              mode = xss_pkg::M_PI_TARGET; cur = 0; f_mis = 0; redo = 1;
            end else f_inv = 1;
          end
          xss_pkg::M_PI_TARGET: begin
            if (xss_pkg::is_name_char(c)) begin
              if (cur >= 3 || c != xss_pkg::xml_char(cur[1:0])) f_mis = 1;
              if (cur < 63) cur++;
            end else begin
              mode = xss_pkg::M_PI_BODY; quote = 0; f_q = 0; redo = 1;
            end
          end
          xss_pkg::M_PI_BODY: begin
            if (quote != 0) begin
              if (c == quote) quote = 0;
            end else if (f_q && c == ">") begin
              if (!f_seen && !f_mis && cur == 3) bump(xss_pkg::C_XMLDECL);
              f_q = 0; mode = xss_pkg::M_TEXT;
            end else begin
              f_q = 0;
              if (c == "'" || c == "\"") quote = c;
              else if (c == "?") f_q = 1;
              else if (c == "<") f_inv = 1;
            end
          end
          xss_pkg::M_DOCTYPE: begin
            if (quote != 0) begin
              if (c == quote) quote = 0;
            end else if (c == "'" || c == "\"") quote = c;
            else if (c == "[") begin
              if (subset < 65535) subset++;
            end else if (c == "]" && subset > 0) subset--;
            else if (c == ">" && subset == 0) begin
              bump(xss_pkg::C_DOCTYPE); mode = xss_pkg::M_TEXT;
            end
          end
          xss_pkg::M_ETAG_START: begin
            if (xss_pkg::is_name_start(c)) begin
              mode = xss_pkg::M_ETAG_NAME; cur = 0; f_mis = 0; redo = 1;
            end else f_inv = 1;
          end
          xss_pkg::M_ETAG_NAME: begin
            if (xss_pkg::is_name_char(c)) begin
              if (cur >= NMAX) f_stop = 1;
              else begin
                if (depth == 0 || depth > DEPTH || cur >= lens[depth-1]
                    || names[depth-1][cur] != c) f_mis = 1;
                cur++;
              end
            end else begin
              if (depth == 0 || depth > DEPTH || cur != lens[depth-1]) f_mis = 1;
              mode = xss_pkg::M_ETAG_WS; redo = 1;
            end
          end
          xss_pkg::M_ETAG_WS: begin
            if (!xss_pkg::is_ws(c)) begin
              if (c == ">" && !f_mis && depth > 0) begin
                bump(xss_pkg::C_END); bump(xss_pkg::C_MATCHED); depth--;
                if (depth == 0) f_closed = 1;
                mode = xss_pkg::M_TEXT;
              end else f_inv = 1;
            end
          end
          xss_pkg::M_TAG_NAME: begin
            if (xss_pkg::is_name_char(c)) begin
              if (cur >= NMAX) f_stop = 1;
              else begin
                if (depth < DEPTH) names[depth][cur] = c;
                cur++;
              end
            end else begin
              if (depth < DEPTH) lens[depth] = cur;
              mode = xss_pkg::M_TAG_LOOP; f_sep = 0; redo = 1;
            end
          end
          xss_pkg::M_TAG_LOOP: begin
            if (xss_pkg::is_ws(c)) f_sep = 1;
            else if (c == ">") close_tag(0);
            else if (c == "/") mode = xss_pkg::M_TAG_SLASH;
            else if (!f_sep || !xss_pkg::is_name_start(c)) f_inv = 1;
            else begin
              mode = xss_pkg::M_ATTR_NAME; cur = 0; f_mis = 0; redo = 1;
            end
          end
          xss_pkg::M_TAG_SLASH: if (c == ">") close_tag(1); else f_inv = 1;
          xss_pkg::M_ATTR_NAME: begin
            if (xss_pkg::is_name_char(c)) begin
              if (cur < 6 && c != ns[cur]) f_mis = 1;
              if (cur < 63) cur++;
            end else begin
              mode = xss_pkg::M_ATTR_EQ; redo = 1;
            end
          end
          xss_pkg::M_ATTR_EQ: if (!xss_pkg::is_ws(c)) begin
            if (c == "=") mode = xss_pkg::M_ATTR_VALWS; else f_inv = 1;
          end
          xss_pkg::M_ATTR_VALWS: if (!xss_pkg::is_ws(c)) begin
            if (c == "'" || c == "\"") begin
              quote = c; mode = xss_pkg::M_ATTR_VALUE;
            end else f_inv = 1;
          end
          xss_pkg::M_ATTR_VALUE: begin
            if (c == quote) begin
              if (pend_attr < CMAX) pend_attr++;
              if (!f_mis && (cur == 5 || cur > 6) && pend_ns < CMAX) pend_ns++;
              quote = 0; f_sep = 0; mode = xss_pkg::M_TAG_LOOP;
            end else if (c == "<") mode = xss_pkg::M_VALUE_LT;
          end
          default: f_inv = 1;
        endcase
      end while (redo && !f_inv && !f_stop);
    endfunction

    function evidence_t summarize();
      evidence_t e;
      longint s, t;
      e = '0;
      if (f_inv || !f_seen) return e;
      t = cnt[xss_pkg::C_START] + cnt[xss_pkg::C_END];
      e.tags = (t > 65535) ? 16'hFFFF : t[15:0];
      s = 2 * ((cnt[xss_pkg::C_START] < 12) ? cnt[xss_pkg::C_START] : 12)
        + 4 * ((cnt[xss_pkg::C_MATCHED] < 8) ? cnt[xss_pkg::C_MATCHED] : 8)
        + ((cnt[xss_pkg::C_ATTR] < 8) ? cnt[xss_pkg::C_ATTR] : 8)
        + 10 * longint'(cnt[xss_pkg::C_XMLDECL]) + 8 * longint'(cnt[xss_pkg::C_DOCTYPE])
        + 8 * ((cnt[xss_pkg::C_XMLNS] < 2) ? cnt[xss_pkg::C_XMLNS] : 2)
        + 2 * ((cnt[xss_pkg::C_COMMENT] < 2) ? cnt[xss_pkg::C_COMMENT] : 2)
        + 4 * ((cnt[xss_pkg::C_CDATA] < 2) ? cnt[xss_pkg::C_CDATA] : 2);
      e.score = (s > 2097151) ? 21'h1FFFFF : s[20:0];
      t = cnt[xss_pkg::C_MATCHED]
        + 2 * (longint'(cnt[xss_pkg::C_XMLDECL]) + cnt[xss_pkg::C_DOCTYPE]
               + cnt[xss_pkg::C_XMLNS])
        + (f_closed ? 2 : 0);
      e.sigs = (t > 4) ? 3'd4 : t[2:0];
      e.decisive = (cnt[xss_pkg::C_START] > 0 && (cnt[xss_pkg::C_XMLDECL] > 0
                    || cnt[xss_pkg::C_DOCTYPE] > 0 || cnt[xss_pkg::C_XMLNS] > 0))
                 || (f_closed && cnt[xss_pkg::C_MATCHED] >= 2)
                 || (cnt[xss_pkg::C_START] >= 3 && cnt[xss_pkg::C_MATCHED] >= 2)
                 || (cnt[xss_pkg::C_START] >= 4 && cnt[xss_pkg::C_SELF] >= 2);
      return e;
    endfunction

    // Note one accepted input word.
    function void note_byte(logic [7:0] c, logic last);
      if (seen < limit) begin
        seen++;
        if (!f_inv && !f_stop) scan(c);
      end
      if (!last) return;
      if (!f_inv && !f_stop && mode inside {xss_pkg::M_BOM1, xss_pkg::M_BOM2,
          xss_pkg::M_BANG, xss_pkg::M_KW_COMMENT, xss_pkg::M_KW_CDATA,
          xss_pkg::M_KW_DOCTYPE, xss_pkg::M_PI_START, xss_pkg::M_TAG_SLASH}) f_inv = 1;
      pending.push_back(summarize());
      restart();
    endfunction

    // Check one accepted output word against the oldest expectation.
    function void check_result(evidence_t got);
      evidence_t want;
      results++;
      if (pending.size() == 0) begin
        $error("unexpected result word %h", got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.tags != want.tags) begin
        $error("structural_tags: expected %0d, got %0d", want.tags, got.tags); errors++;
      end
      if (got.score != want.score) begin
        $error("score: expected %0d, got %0d", want.score, got.score); errors++;
      end
      if (got.sigs != want.sigs) begin
        $error("strong_signals: expected %0d, got %0d", want.sigs, got.sigs); errors++;
      end
      if (got.decisive != want.decisive) begin
        $error("decisive: expected %0d, got %0d", want.decisive, got.decisive); errors++;
      end
    endfunction
  endclass

  logic        clk_i, rst_ni;
  logic        s_axis_tvalid, s_axis_tready, s_axis_tlast;
  logic [7:0]  s_axis_tdata;
  logic        m_axis_tvalid, m_axis_tready;
  logic [47:0] m_axis_tdata;
  logic        psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;

  xml_structure_sniffer_unit dut (.*);

  sniff_board board;
  logic [7:0] text_buf[$];
  int         bytes_sent, texts_sent, cycles;
  bit         sending_done;

  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  // Watchdog: the run is far shorter than this even with maximal stalls.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > 400000) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Monitor: check every accepted output word; drive tready with random stalls.
  initial begin
    int wait_n;
    m_axis_tready = 0;
    @(posedge rst_ni);
    forever begin
      wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
      if (wait_n > 0) begin
        m_axis_tready <= 0;
        repeat (wait_n) @(posedge clk_i);
      end
      m_axis_tready <= 1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      board.check_result(evidence_t'(m_axis_tdata[40:0]));
    end
  end

  // Write one register over APB: setup then access.
  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= data;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    if (addr == ADDR_SAMPLE_LIMIT) board.limit = data[16:0];
  endtask

  // Send the buffered text, last byte marked; random gap before each word when gaps is set.
  task automatic send_text(bit gaps);
    int wait_n;
    for (int k = 0; k < text_buf.size(); k++) begin
      wait_n = gaps ? $urandom_range(0, 9) : 0;
      if (wait_n > 0) begin
        s_axis_tvalid <= 0;
        repeat (wait_n) @(posedge clk_i);
      end
      s_axis_tvalid <= 1;
      s_axis_tdata  <= text_buf[k];
      s_axis_tlast  <= (k == text_buf.size() - 1);
      do @(posedge clk_i); while (!s_axis_tready);
      board.note_byte(text_buf[k], k == text_buf.size() - 1);
      bytes_sent++;
    end
    texts_sent++;
    text_buf.delete();
  endtask

  task automatic push_str(string s);
    for (int k = 0; k < s.len(); k++) text_buf.push_back(s[k]);
  endtask

  // Drain: drop the input, wait for every expected word, then let the pipeline settle.
  task automatic drain();
    s_axis_tvalid <= 0;
    s_axis_tlast  <= 0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic string rand_name(int maxlen);
    string s, pool;
    pool = "abcdefxyzAZ_:-.09";
    s = "";
    s = {s, string'(pool[$urandom_range(0, 12)])};
    repeat ($urandom_range(0, maxlen - 1)) s = {s, string'(pool[$urandom_range(0, 16)])};
    return s;
  endfunction

  // Build a random element tree; mostly well formed, with xmlns attributes.
  function automatic string rand_elem(int lvl);
    string nm, s;
    nm = rand_name(6);
    s = {"<", nm};
    repeat ($urandom_range(0, 2)) begin
      if ($urandom_range(0, 2) == 0) begin
        s = {s, " xmlns", ($urandom_range(0, 1) ? string'(":p") : string'("")), "='u'"};
      end else begin
        s = {s, " ", rand_name(4), " = \"",
             (($urandom_range(0, 3) == 0) ? string'("v<w") : string'("v w")), "\""};
      end
    end
    if (lvl > 3 || $urandom_range(0, 3) == 0) begin
      return {s, ($urandom_range(0, 1) ? string'(" ") : string'("")), "/>"};
    end
    s = {s, ">"};
    repeat ($urandom_range(0, 3)) begin
      case ($urandom_range(0, 4))
        0: s = {s, "t x"};
        1: s = {s, "<!-- c-->"};
        2: s = {s, "<![CDATA[a]]>"};
        default: s = {s, rand_elem(lvl + 1)};
      endcase
    end
    return {s, "</", nm, ($urandom_range(0, 1) ? string'(" ") : string'("")), ">"};
  endfunction

  function automatic void corrupt();
    int n;
    n = text_buf.size();
    case ($urandom_range(0, 3))
      0: if (n > 1) text_buf.delete($urandom_range(0, n - 1));
      1: text_buf[$urandom_range(0, n - 1)] = 8'($urandom_range(0, 255));
      2: repeat ($urandom_range(1, 20)) text_buf.push_back(8'($urandom_range(0, 255)));
      default: if (n > 2) text_buf = text_buf[0:$urandom_range(0, n - 2)];
    endcase
  endfunction

  initial begin
    string s;
    board = new();
    board.limit = xss_pkg::LIMIT_RESET;
    board.restart();
    board.errors = 0; board.results = 0;
    bytes_sent = 0; texts_sent = 0;
    rst_ni = 0; s_axis_tvalid = 0; s_axis_tdata = 0; s_axis_tlast = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed texts: BOM, declarations, doctype subset, every tag kind, error endings.
    push_str("\xEF\xBB\xBF<?xml version='1.0'?><!DOCTYPE r [<!ENTITY a \"]\">]><r/>");
    send_text(0);
    push_str("<a xmlns:b='x' c=\"y\"><b>t</b><!--x--><![CDATA[]]]]><c/><d/></a>");
    send_text(1);
    push_str("<a><b></c></a>"); send_text(0);
    push_str("<a></a><b/>"); send_text(1);
    push_str("\xEF\xBB"); send_text(0);
    push_str("<a><!DOC"); send_text(0);
    push_str("<a/"); send_text(0);
    push_str("<?"); send_text(0);
    push_str("<a><!"); send_text(0);
    push_str("  <a>"); send_text(0);
    push_str("x"); send_text(0);
    text_buf.push_back(8'hFF); text_buf.push_back(8'h00); send_text(1);
    s = "<";
    repeat (NMAX + 1) s = {s, "q"};
    push_str({s, ">"}); send_text(0);
    repeat (DEPTH + 1) push_str("<e>");
    send_text(0);
    push_str("<?xmlx a?><r></r >"); send_text(0);
    drain();

    // Sample limit extremes: zero, one, a small cut, the largest value.
    apb_write(ADDR_SAMPLE_LIMIT, 0);
    push_str("<r/>"); send_text(0);
    drain();
    apb_write(ADDR_SAMPLE_LIMIT, 1);
    push_str("<r/>"); send_text(1);
    drain();
    apb_write(ADDR_SAMPLE_LIMIT, 6);
    push_str("<r/><x"); send_text(0);
    push_str("<ab/>junk<<"); send_text(1);
    drain();
    apb_write(ADDR_SAMPLE_LIMIT, 32'h1FFFF);

    // Random phase: mostly well-formed trees, some broken ones and some led by random noise.
    while (bytes_sent < 850) begin
      if (texts_sent % 25 == 0) begin
        drain();
        apb_write(ADDR_SAMPLE_LIMIT, ($urandom_range(0, 3) == 0)
                  ? $urandom_range(1, 40) : 32'h10000);
      end
      case ($urandom_range(0, 9))
        0: repeat ($urandom_range(1, 12)) text_buf.push_back(8'($urandom_range(0, 255)));
        1: push_str("<?xml v='1'?>");
        2: push_str("<!DOCTYPE r [ 'a]' ]>");
        default: ;
      endcase
      push_str(rand_elem(0));
      if ($urandom_range(0, 4) == 0) corrupt();
      send_text($urandom_range(0, 2) != 0);
    end

    drain();
    $display("Sent %0d bytes in %0d texts; checked %0d evidence words.",
             bytes_sent, texts_sent, board.results);
    if (board.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

FILE: sim.f
src/xss_pkg.sv
src/xss_scan.sv
src/xss_emit.sv
src/xml_structure_sniffer_unit.sv
src/xss_checker.sv
test/tb.sv
